[design/oef_pkg.sv]
// shared types and constants of the six-channel one euro filter
`default_nettype none
package oef_pkg;

  localparam int CHANNELS  = 6;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int SAMPLE_W  = 32;
  localparam int FRAC_BITS = 16;
  localparam int TIME_W    = 48;
  localparam int DT_W      = 20;
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 2;
  localparam int PROD_W    = CFG_W + DT_W;
  localparam int DIV_W     = PROD_W + 2;
  localparam int QUOT_W    = 32;
  localparam int STEP_W    = 6;

  localparam logic [DIV_W-1:0] ALPHA_K   = DIV_W'(64'd10430378356);
  localparam logic [DT_W-1:0]  US_PER_S  = DT_W'(1000000);
  localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(FRAC_BITS);
  localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(SAMPLE_W - 1);

  localparam logic [CFG_W-1:0] MIN_CUTOFF_RST   = 32'd131072;
  localparam logic [CFG_W-1:0] SPEED_COEF_RST   = 32'd16384;
  localparam logic [CFG_W-1:0] DERIV_CUTOFF_RST = 32'd65536;
  localparam logic [DT_W-1:0]  MAX_INTERVAL_RST = 20'd100000;

  localparam logic [IDX_W-1:0] REG_MIN_CUTOFF   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SPEED_COEF   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_CUTOFF = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX_INTERVAL = 2'd3;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  rem;
    logic [QUOT_W-1:0] bits;
    logic [DIV_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_AD_MUL, ST_AD_DIV, ST_AD_WAIT,
    ST_R_MUL, ST_R_DIV, ST_R_WAIT, ST_R_BLEND,
    ST_C_MUL, ST_V_MUL, ST_V_DIV, ST_V_WAIT, ST_V_BLEND, ST_OUT
  } oef_state_t;

endpackage
`default_nettype wire

[design/oef_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module oef_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire oef_pkg::div_req_t req,
  output oef_pkg::div_rsp_t     rsp
);

  logic                        busy;
  logic [oef_pkg::STEP_W-1:0]  cnt;
  logic [oef_pkg::DIV_W-1:0]   rem;
  logic [oef_pkg::DIV_W-1:0]   den;
  logic [oef_pkg::QUOT_W-1:0]  bits;
  logic [oef_pkg::QUOT_W-1:0]  quot;
  logic                        done;
  logic [oef_pkg::DIV_W-1:0]   trial;
  logic                        take;

  assign trial = {rem[oef_pkg::DIV_W-2:0], bits[oef_pkg::QUOT_W-1]};
  assign take  = trial >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == oef_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem;
      den  <= req.den;
      bits <= req.bits;
      quot <= '0;
    end else if (busy) begin
      rem  <= take ? trial - den : trial;
      quot <= {quot[oef_pkg::QUOT_W-2:0], take};
      bits <= {bits[oef_pkg::QUOT_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den) else $error("partial remainder not below divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && cnt != oef_pkg::STEP_W'(1) |-> !req.start)
    else $error("divider restarted mid operation");

endmodule
`default_nettype wire

[design/one_euro_filter_6ch.sv]
// six-channel one euro adaptive low-pass filter, top level
// input channel s_*: one item holds six Q16.16 samples and a microsecond
// timestamp in s_tdata, and the selector in s_tuser (0 filter, 1 anchor).
// output channel m_*: one item holds six filtered values and six filtered
// rates, Q16.16. an anchor item gives no output item.
// configuration: cfg_we writes cfg_data to register cfg_index (0 min cutoff,
// 1 speed coefficient, 2 derivative cutoff, 3 max interval); the user must
// write only while idle, which the block itself does not enforce.
// one item is worked at a time. a filter item with a nonzero interval raises
// its output item after all six channels are worked: a shared bit-serial
// divider gives one quotient bit a cycle, 16 bits for each of seven alphas
// and 31 bits for each of six channel rates; a channel whose rate saturates
// skips its division. channel state rotates through word registers.
// an anchor item passes the start step and returns to idle; a first or
// zero-interval filter item goes from the start step to the output step.
// the result sits in an output register, so the next item is accepted while
// it waits; if the receiver still stalls when the next result is ready the
// block holds in its output step. reset restores the register defaults and
// clears the channel state and the primed flag.
`default_nettype none
module one_euro_filter_6ch (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // sample_0..sample_5 (32 each), timestamp_us (48)
  input  wire logic [239:0] s_tdata,
  // func
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // smoothed_0..smoothed_5 (32 each), rate_0..rate_5 (32 each)
  output logic [383:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int SW = oef_pkg::SAMPLE_W;
  localparam int NC = oef_pkg::CHANNELS;

  function automatic logic signed [SW-1:0] blend(input logic signed [SW-1:0] y,
                                                  input logic signed [SW-1:0] x,
                                                  input logic [oef_pkg::FRAC_BITS-1:0] a);
    logic signed [SW:0]                    d;
    logic signed [SW+oef_pkg::FRAC_BITS+1:0] p;
    logic signed [SW+1:0]                  s;
    d = {x[SW-1], x} - {y[SW-1], y};
    p = d * $signed({1'b0, a});
    s = {{2{y[SW-1]}}, y} + p[SW+oef_pkg::FRAC_BITS+1:oef_pkg::FRAC_BITS];
    return s[SW-1:0];
  endfunction

  logic [oef_pkg::CFG_W-1:0] min_cutoff, speed_coef, deriv_cutoff;
  logic [oef_pkg::DT_W-1:0]  max_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cutoff   <= oef_pkg::MIN_CUTOFF_RST;
      speed_coef   <= oef_pkg::SPEED_COEF_RST;
      deriv_cutoff <= oef_pkg::DERIV_CUTOFF_RST;
      max_interval <= oef_pkg::MAX_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        oef_pkg::REG_MIN_CUTOFF:   min_cutoff   <= cfg_data;
        oef_pkg::REG_SPEED_COEF:   speed_coef   <= cfg_data;
        oef_pkg::REG_DERIV_CUTOFF: deriv_cutoff <= cfg_data;
        oef_pkg::REG_MAX_INTERVAL: max_interval <= cfg_data[oef_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  oef_pkg::oef_state_t state, state_next;

  logic signed [SW-1:0] smp  [NC];
  logic signed [SW-1:0] prev [NC];
  logic signed [SW-1:0] filt [NC];
  logic signed [SW-1:0] frate[NC];
  logic signed [SW-1:0] out_val [NC];
  logic signed [SW-1:0] out_rate[NC];
  logic                 primed;
  logic                 func_r;
  logic [oef_pkg::TIME_W-1:0] now_r, last_time;
  logic [oef_pkg::DT_W-1:0]   dt;
  logic [oef_pkg::CH_W-1:0]   ch;
  logic [oef_pkg::PROD_W-1:0] prod;
  logic                       neg;
  logic signed [SW-1:0]       rinst;
  logic [oef_pkg::FRAC_BITS-1:0] alpha;
  logic [oef_pkg::CFG_W-1:0]  cutoff;

  oef_pkg::div_req_t div_req;
  oef_pkg::div_rsp_t div_rsp;

  oef_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // interval
  logic [oef_pkg::TIME_W-1:0] diff;
  logic [oef_pkg::DT_W-1:0]   dt_c;
  assign diff = now_r - last_time;
  always_comb begin
    if (now_r <= last_time)
      dt_c = '0;
    else if (diff > oef_pkg::TIME_W'(max_interval))
      dt_c = max_interval;
    else
      dt_c = diff[oef_pkg::DT_W-1:0];
  end

  // channel rate numerator
  logic signed [SW:0]         d_raw;
  logic [SW-1:0]              m_raw;
  assign d_raw = {smp[0][SW-1], smp[0]} - {prev[0][SW-1], prev[0]};
  assign m_raw = d_raw[SW] ? SW'(-d_raw) : d_raw[SW-1:0];

  logic sat;
  assign sat = prod[oef_pkg::PROD_W-1:SW-1] >= {1'b0, dt};

  // adaptive cutoff
  logic [SW-1:0]           m_rate;
  logic [2*SW-1:0]         cprod;
  logic [2*SW-oef_pkg::FRAC_BITS:0] csum;
  assign m_rate = frate[0][SW-1] ? SW'(-frate[0]) : frate[0];
  assign cprod  = speed_coef * m_rate;
  assign csum   = (2*SW-oef_pkg::FRAC_BITS+1)'(min_cutoff)
                + {1'b0, cprod[2*SW-1:oef_pkg::FRAC_BITS]};

  logic last_ch;
  assign last_ch = ch == oef_pkg::CH_W'(NC - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      oef_pkg::ST_IDLE:    if (s_tvalid) state_next = oef_pkg::ST_START;
      oef_pkg::ST_START: begin
        if (func_r) state_next = oef_pkg::ST_IDLE;
        else if (!primed || dt_c == '0) state_next = oef_pkg::ST_OUT;
        else state_next = oef_pkg::ST_AD_MUL;
      end
      oef_pkg::ST_AD_MUL:  state_next = oef_pkg::ST_AD_DIV;
      oef_pkg::ST_AD_DIV:  state_next = oef_pkg::ST_AD_WAIT;
      oef_pkg::ST_AD_WAIT: if (div_rsp.done) state_next = oef_pkg::ST_R_MUL;
      oef_pkg::ST_R_MUL:   state_next = oef_pkg::ST_R_DIV;
      oef_pkg::ST_R_DIV:   state_next = sat ? oef_pkg::ST_R_BLEND : oef_pkg::ST_R_WAIT;
      oef_pkg::ST_R_WAIT:  if (div_rsp.done) state_next = oef_pkg::ST_R_BLEND;
      oef_pkg::ST_R_BLEND: state_next = last_ch ? oef_pkg::ST_C_MUL : oef_pkg::ST_R_MUL;
      oef_pkg::ST_C_MUL:   state_next = oef_pkg::ST_V_MUL;
      oef_pkg::ST_V_MUL:   state_next = oef_pkg::ST_V_DIV;
      oef_pkg::ST_V_DIV:   state_next = oef_pkg::ST_V_WAIT;
      oef_pkg::ST_V_WAIT:  if (div_rsp.done) state_next = oef_pkg::ST_V_BLEND;
      oef_pkg::ST_V_BLEND: state_next = last_ch ? oef_pkg::ST_OUT : oef_pkg::ST_C_MUL;
      oef_pkg::ST_OUT:     if (!m_tvalid || m_tready) state_next = oef_pkg::ST_IDLE;
      default:             state_next = oef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = state == oef_pkg::ST_IDLE;
    div_req.start = 1'b0;
    div_req.steps = oef_pkg::FRAC_STEPS;
    div_req.rem   = oef_pkg::DIV_W'(prod);
    div_req.bits  = '0;
    div_req.den   = oef_pkg::DIV_W'(prod) + oef_pkg::ALPHA_K;
    unique case (state)
      oef_pkg::ST_AD_DIV, oef_pkg::ST_V_DIV: div_req.start = 1'b1;
      oef_pkg::ST_R_DIV: begin
        div_req.start = !sat;
        div_req.steps = oef_pkg::RATE_STEPS;
        div_req.rem   = oef_pkg::DIV_W'(prod[oef_pkg::PROD_W-1:SW-1]);
        div_req.bits  = {prod[SW-2:0], 1'b0};
        div_req.den   = oef_pkg::DIV_W'(dt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oef_pkg::ST_IDLE;
      primed    <= 1'b0;
      m_tvalid  <= 1'b0;
      last_time <= '0;
      ch        <= '0;
      for (int i = 0; i < NC; i++) begin
        prev[i]  <= '0;
        filt[i]  <= '0;
        frate[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == oef_pkg::ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        oef_pkg::ST_START: begin
          dt <= dt_c;
          ch <= '0;
          if (func_r || !primed) begin
            for (int i = 0; i < NC; i++) begin
              prev[i]  <= smp[i];
              filt[i]  <= smp[i];
              frate[i] <= '0;
            end
            last_time <= now_r;
            primed    <= 1'b1;
          end
        end
        oef_pkg::ST_R_BLEND: begin
          for (int i = 0; i < NC - 1; i++) begin
            frate[i] <= frate[i+1];
            prev[i]  <= prev[i+1];
          end
          frate[NC-1] <= blend(frate[0], rinst, alpha);
          prev[NC-1]  <= prev[0];
          ch <= last_ch ? '0 : ch + 1'b1;
        end
        oef_pkg::ST_V_BLEND: begin
          for (int i = 0; i < NC - 1; i++) begin
            frate[i] <= frate[i+1];
            prev[i]  <= prev[i+1];
            filt[i]  <= filt[i+1];
          end
          frate[NC-1] <= frate[0];
          prev[NC-1]  <= smp[0];
          filt[NC-1]  <= blend(filt[0], smp[0], alpha);
          ch <= last_ch ? '0 : ch + 1'b1;
          if (last_ch) last_time <= now_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      oef_pkg::ST_IDLE: if (s_tvalid) begin
        for (int i = 0; i < NC; i++) smp[i] <= s_tdata[i*SW +: SW];
        now_r  <= s_tdata[NC*SW +: oef_pkg::TIME_W];
        func_r <= s_tuser[0];
      end
      oef_pkg::ST_AD_MUL:  prod <= deriv_cutoff * dt;
      oef_pkg::ST_AD_WAIT: if (div_rsp.done) alpha <= div_rsp.quot[oef_pkg::FRAC_BITS-1:0];
      oef_pkg::ST_R_MUL: begin
        prod <= m_raw * oef_pkg::US_PER_S;
        neg  <= d_raw[SW];
      end
      oef_pkg::ST_R_DIV:
        if (sat) rinst <= neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      oef_pkg::ST_R_WAIT:
        if (div_rsp.done) rinst <= neg ? -$signed(div_rsp.quot[SW-1:0])
                                       : $signed(div_rsp.quot[SW-1:0]);
      oef_pkg::ST_R_BLEND: begin
        for (int i = 0; i < NC - 1; i++) smp[i] <= smp[i+1];
        smp[NC-1] <= smp[0];
      end
      oef_pkg::ST_C_MUL:
        cutoff <= (csum[2*SW-oef_pkg::FRAC_BITS:SW] != '0) ? '1 : csum[SW-1:0];
      oef_pkg::ST_V_MUL:   prod <= cutoff * dt;
      oef_pkg::ST_V_WAIT:  if (div_rsp.done) alpha <= div_rsp.quot[oef_pkg::FRAC_BITS-1:0];
      oef_pkg::ST_V_BLEND: begin
        for (int i = 0; i < NC - 1; i++) smp[i] <= smp[i+1];
        smp[NC-1] <= smp[0];
      end
      oef_pkg::ST_OUT: if (!m_tvalid || m_tready) begin
        for (int i = 0; i < NC; i++) begin
          out_val[i]  <= filt[i];
          out_rate[i] <= frate[i];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      m_tdata[i*SW +: SW]      = out_val[i];
      m_tdata[(NC+i)*SW +: SW] = out_rate[i];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");
  a_out_primed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> primed) else $error("output item before priming");
  a_dt_bound: assert property (@(posedge clk) disable iff (rst)
    dt_c <= max_interval) else $error("interval above its clamp");

endmodule
`default_nettype wire
